>>> rtl/core/bse_pkg.sv
package bse_pkg;

    localparam logic [63:0] C_7_3    = 64'd10021590357;
    localparam logic [63:0] C_14_3   = 64'd20043180715;
    localparam logic [63:0] C_HALF_E = 64'd309092690166;
    localparam logic [63:0] C_FULL_E = 64'd618185380332;
    localparam logic [63:0] MAX48    = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX47    = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] MAX63    = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 64;
    localparam int MUL_PARTS  = 4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT, ST_D2, ST_P, ST_KD, ST_KDP, ST_E,
        ST_Q, ST_K1, ST_KQ, ST_GM, ST_DIV, ST_C, ST_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  shift;
        logic        sat;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic [63:0]  res;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [65:0] op;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [33:0] root;
    } t_sqrt_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [33:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/core/bse_mul.sv
module bse_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bse_pkg::t_mul_req i_req,
    output bse_pkg::t_mul_rsp o_rsp
);
    import bse_pkg::*;

    logic [63:0]  r_a, r_b, r_res;
    logic [5:0]   r_sh;
    logic         r_sat, r_busy, r_done;
    logic [127:0] r_acc;
    logic [2:0]   r_step;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh, sh_full;
    logic [63:0]  hi_sh;

    // one 32x32 partial product per cycle
    always_comb begin
        pa      = r_step[0] ? r_a[63:32] : r_a[31:0];
        pb      = r_step[1] ? r_b[63:32] : r_b[31:0];
        pp      = pa * pb;
        pp_sh   = {64'd0, pp} << ((7'(r_step[0]) + 7'(r_step[1])) * 7'd32);
        sh_full = r_acc >> r_sh;
        hi_sh   = r_acc[127:64] >> r_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_sh   <= i_req.shift;
                r_sat  <= i_req.sat;
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step < 3'(MUL_PARTS)) begin
                    r_acc  <= r_acc + pp_sh;
                    r_step <= r_step + 3'd1;
                end else begin
                    if (r_sat) begin
                        r_res <= (hi_sh != '0) ? '1 : sh_full[63:0];
                    end else begin
                        r_res <= r_acc[63:0] >> r_sh;
                    end
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.prod = r_acc;

endmodule

>>> rtl/core/bse_sqrt.sv
module bse_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bse_pkg::t_sqrt_req i_req,
    output bse_pkg::t_sqrt_rsp o_rsp
);
    import bse_pkg::*;

    logic [67:0] r_op;
    logic [36:0] r_rem;
    logic [33:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [36:0] rem_sh, trial;
    logic        take;

    always_comb begin
        rem_sh = {r_rem[34:0], r_op[67:66]};
        trial  = {1'b0, r_root, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op   <= {2'b00, i_req.op};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_op   <= {r_op[65:0], 2'b00};
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[32:0], take};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

>>> rtl/core/bse_div.sv
module bse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bse_pkg::t_div_req i_req,
    output bse_pkg::t_div_rsp o_rsp
);
    import bse_pkg::*;

    logic [63:0] r_q;
    logic [33:0] r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [34:0] rem_sh, diff;
    logic        take;

    always_comb begin
        rem_sh = {r_rem, r_q[63]};
        diff   = rem_sh - {1'b0, r_den};
        take   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? diff[33:0] : rem_sh[33:0];
                r_q   <= {r_q[62:0], take};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

>>> rtl/core/bond_stretch_energy_gradient.sv
// channel   dir  signals                      word
// s_axis    in   tvalid tready tdata tlast    one bond, tlast = last bond
// m_axis    out  tvalid tready tdata tlast    one result, tlast = run end
//                tuser                        tuser = saturated
// cfg       in   i_cfg_wr_en i_cfg_wr_data    gradient mode bit
//
// One bond per pass through a sequencer around a shared multiplier that takes
// four 32x32 partial products, a 34-step square root and a 64-step divider.
// Input is ready only in idle. A finished word waits in the output
// register; the next bond is accepted meanwhile. Reset clears sums and mode.
module bond_stretch_energy_gradient #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_idx, b_idx, a_x, a_y, a_z, b_x, b_y, b_z, force_const, rest_length, pad
    input  logic [271:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // a_idx, b_idx, grad_x, grad_y, grad_z, bond_energy, energy_total, pad
    output logic [287:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // saturated
    output logic         m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data
);
    import bse_pkg::*;

    localparam logic [5:0]  FB  = 6'(FRAC_BITS);
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    function automatic logic [63:0] poly_fin(input logic [63:0] t, input logic [63:0] lin,
                                             input logic dneg);
        logic [64:0] s1, s2;
        logic [63:0] base;
        s1   = {1'b0, ONE} + {1'b0, t};
        base = s1[64] ? '1 : s1[63:0];
        s2   = {1'b0, base} + {1'b0, lin};
        if (dneg) begin
            poly_fin = s2[64] ? '1 : s2[63:0];
        end else begin
            poly_fin = (base < lin) ? '0 : base - lin;
        end
    endfunction

    t_state r_state, n_state;
    logic r_issued, n_issued;
    logic [1:0] r_idx, n_idx;
    logic [32:0] r_mag [3], n_mag [3];
    logic r_neg [3], n_neg [3];
    logic [47:0] r_g [3], n_g [3];
    logic [65:0] r_sum, n_sum;
    logic [33:0] r_r, n_r, r_dmag, n_dmag;
    logic r_dneg, n_dneg;
    logic [63:0] r_d2, n_d2, r_t, n_t, r_p, n_p, r_gm, n_gm, r_unit, n_unit;
    logic [47:0] r_e, n_e;
    logic r_esat, n_esat;
    logic [15:0] r_ai, n_ai, r_bi, n_bi;
    logic [23:0] r_kb, n_kb;
    logic [19:0] r_r0, n_r0;
    logic r_last, n_last;
    logic r_gmode;
    logic [62:0] r_esum, n_esum;
    logic r_satseen, n_satseen;
    logic r_ovalid, n_ovalid;
    logic [287:0] r_odata, n_odata;
    logic r_olast, n_olast, r_osat, n_osat;

    t_mul_req  mul_req;
    t_mul_rsp  mul_rsp;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    logic [32:0] diff [3];
    logic [63:0] lin2, lin3, cval;
    logic [47:0] cmag;
    logic [63:0] sum64;
    logic        sum_ovf;

    bse_mul  u_mul  (.i_clk, .i_rst_n, .i_req(mul_req),  .o_rsp(mul_rsp));
    bse_sqrt u_sqrt (.i_clk, .i_rst_n, .i_req(sqrt_req), .o_rsp(sqrt_rsp));
    bse_div  u_div  (.i_clk, .i_rst_n, .i_req(div_req),  .o_rsp(div_rsp));

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        diff[0] = {s_axis_tdata[63], s_axis_tdata[63:32]}
                - {s_axis_tdata[159], s_axis_tdata[159:128]};
        diff[1] = {s_axis_tdata[95], s_axis_tdata[95:64]}
                - {s_axis_tdata[191], s_axis_tdata[191:160]};
        diff[2] = {s_axis_tdata[127], s_axis_tdata[127:96]}
                - {s_axis_tdata[223], s_axis_tdata[223:192]};
        lin2  = {29'd0, r_dmag, 1'b0};
        lin3  = lin2 + {30'd0, r_dmag};
        cval  = (mul_rsp.res > MAX47) ? MAX47 : mul_rsp.res;
        cmag  = cval[47:0];
        sum64 = {1'b0, r_esum} + {16'd0, r_e};
        sum_ovf = (sum64 > MAX63);
    end

    always_comb begin
        n_state = r_state; n_issued = r_issued; n_idx = r_idx;
        n_mag = r_mag; n_neg = r_neg; n_g = r_g; n_sum = r_sum;
        n_r = r_r; n_dmag = r_dmag; n_dneg = r_dneg; n_d2 = r_d2;
        n_t = r_t; n_p = r_p; n_gm = r_gm; n_unit = r_unit;
        n_e = r_e; n_esat = r_esat; n_ai = r_ai; n_bi = r_bi;
        n_kb = r_kb; n_r0 = r_r0; n_last = r_last;
        n_esum = r_esum; n_satseen = r_satseen;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata; n_olast = r_olast; n_osat = r_osat;
        mul_req  = '0;
        sqrt_req = '0;
        div_req  = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ai   = s_axis_tdata[15:0];
                    n_bi   = s_axis_tdata[31:16];
                    n_kb   = s_axis_tdata[247:224];
                    n_r0   = s_axis_tdata[267:248];
                    n_last = s_axis_tlast;
                    for (int i = 0; i < 3; i++) begin
                        n_neg[i] = diff[i][32];
                        n_mag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
                        n_g[i]   = '0;
                    end
                    n_sum    = '0;
                    n_idx    = '0;
                    n_issued = 1'b0;
                    n_state  = ST_SQ;
                end
            end
            ST_SQ: begin
                if (!r_issued) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {31'd0, r_mag[r_idx]};
                    mul_req.b     = {31'd0, r_mag[r_idx]};
                    n_issued      = 1'b1;
                end else if (mul_rsp.done) begin
                    n_sum    = r_sum + mul_rsp.prod[65:0];
                    n_issued = 1'b0;
                    if (r_idx == 2'd2) begin
                        n_idx   = '0;
                        n_state = ST_SQRT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            ST_SQRT: begin
                if (!r_issued) begin
                    sqrt_req.start = 1'b1;
                    sqrt_req.op    = r_sum;
                    n_issued       = 1'b1;
                end else if (sqrt_rsp.done) begin
                    n_r      = sqrt_rsp.root;
                    n_dneg   = sqrt_rsp.root < {14'd0, r_r0};
                    n_dmag   = n_dneg ? ({14'd0, r_r0} - sqrt_rsp.root)
                                      : (sqrt_rsp.root - {14'd0, r_r0});
                    n_issued = 1'b0;
                    n_state  = ST_D2;
                end
            end
            ST_D2, ST_P, ST_KD, ST_KDP, ST_E, ST_Q, ST_K1, ST_KQ, ST_GM, ST_C: begin
                case (r_state)
                    ST_D2:   begin mul_req.a = {30'd0, r_dmag}; mul_req.b = {30'd0, r_dmag};
                                   mul_req.shift = FB; end
                    ST_P:    begin mul_req.a = r_d2; mul_req.b = C_7_3;
                                   mul_req.shift = 6'd32; mul_req.sat = 1'b1; end
                    ST_KD:   begin mul_req.a = {40'd0, r_kb}; mul_req.b = r_d2;
                                   mul_req.shift = FB; mul_req.sat = 1'b1; end
                    ST_KDP:  begin mul_req.a = r_t; mul_req.b = r_p;
                                   mul_req.shift = FB; mul_req.sat = 1'b1; end
                    ST_E:    begin mul_req.a = r_t; mul_req.b = C_HALF_E;
                                   mul_req.shift = 6'd32; mul_req.sat = 1'b1; end
                    ST_Q:    begin mul_req.a = r_d2; mul_req.b = C_14_3;
                                   mul_req.shift = 6'd32; mul_req.sat = 1'b1; end
                    ST_K1:   begin mul_req.a = {40'd0, r_kb}; mul_req.b = {30'd0, r_dmag};
                                   mul_req.shift = FB; end
                    ST_KQ:   begin mul_req.a = r_t; mul_req.b = r_p;
                                   mul_req.shift = FB; mul_req.sat = 1'b1; end
                    ST_GM:   begin mul_req.a = r_t; mul_req.b = C_FULL_E;
                                   mul_req.shift = 6'd32; mul_req.sat = 1'b1; end
                    default: begin mul_req.a = r_gm; mul_req.b = r_unit;
                                   mul_req.shift = 6'd31; mul_req.sat = 1'b1; end
                endcase
                if (!r_issued) begin
                    mul_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mul_rsp.done) begin
                    n_issued = 1'b0;
                    case (r_state)
                        ST_D2:  begin n_d2 = mul_rsp.res; n_state = ST_P; end
                        ST_P:   begin n_p = poly_fin(mul_rsp.res, lin2, r_dneg);
                                      n_state = ST_KD; end
                        ST_KD:  begin n_t = mul_rsp.res; n_state = ST_KDP; end
                        ST_KDP: begin n_t = mul_rsp.res; n_state = ST_E; end
                        ST_E: begin
                            n_esat  = (mul_rsp.res > MAX48);
                            n_e     = n_esat ? MAX48[47:0] : mul_rsp.res[47:0];
                            n_state = (r_gmode && r_r != '0) ? ST_Q : ST_DONE;
                        end
                        ST_Q:   begin n_p = poly_fin(mul_rsp.res, lin3, r_dneg);
                                      n_state = ST_K1; end
                        ST_K1:  begin n_t = mul_rsp.res; n_state = ST_KQ; end
                        ST_KQ:  begin n_t = mul_rsp.res; n_state = ST_GM; end
                        ST_GM:  begin n_gm = mul_rsp.res; n_idx = '0; n_state = ST_DIV; end
                        default: begin
                            n_g[r_idx] = (r_neg[r_idx] != r_dneg) ? (48'd0 - cmag) : cmag;
                            if (r_idx == 2'd2) begin
                                n_state = ST_DONE;
                            end else begin
                                n_idx   = r_idx + 2'd1;
                                n_state = ST_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (!r_issued) begin
                    div_req.start = 1'b1;
                    div_req.num   = {r_mag[r_idx], 31'd0};
                    div_req.den   = r_r;
                    n_issued      = 1'b1;
                end else if (div_rsp.done) begin
                    n_unit   = div_rsp.quo;
                    n_issued = 1'b0;
                    n_state  = ST_C;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_olast  = r_last;
                    n_osat   = r_satseen | r_esat | sum_ovf;
                    n_odata  = {1'b0, (sum_ovf ? MAX63[62:0] : sum64[62:0]), r_e,
                                r_g[2], r_g[1], r_g[0], r_bi, r_ai};
                    if (r_last) begin
                        n_esum    = '0;
                        n_satseen = 1'b0;
                    end else begin
                        n_esum    = sum_ovf ? MAX63[62:0] : sum64[62:0];
                        n_satseen = n_osat;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issued  <= 1'b0;
            r_idx     <= '0;
            r_gmode   <= 1'b0;
            r_esum    <= '0;
            r_satseen <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issued  <= n_issued;
            r_idx     <= n_idx;
            r_esum    <= n_esum;
            r_satseen <= n_satseen;
            r_ovalid  <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_gmode <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag; r_neg <= n_neg; r_g <= n_g; r_sum <= n_sum;
        r_r <= n_r; r_dmag <= n_dmag; r_dneg <= n_dneg; r_d2 <= n_d2;
        r_t <= n_t; r_p <= n_p; r_gm <= n_gm; r_unit <= n_unit;
        r_e <= n_e; r_esat <= n_esat; r_ai <= n_ai; r_bi <= n_bi;
        r_kb <= n_kb; r_r0 <= n_r0; r_last <= n_last;
        r_odata <= n_odata; r_olast <= n_olast; r_osat <= n_osat;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_osat;

endmodule

>>> dv/tb_bond_stretch_energy_gradient.sv
module tb_bond_stretch_energy_gradient;
    import bse_pkg::*;

    typedef struct {
        logic [15:0] a_idx;
        logic [15:0] b_idx;
        logic [31:0] a_pos [3];
        logic [31:0] b_pos [3];
        logic [23:0] kb;
        logic [19:0] r0;
        logic        last;
    } t_bond;

    typedef struct packed {
        logic [15:0] a_idx;
        logic [15:0] b_idx;
        logic [47:0] gx;
        logic [47:0] gy;
        logic [47:0] gz;
        logic [47:0] energy;
        logic [62:0] total;
        logic        run_end;
        logic        sat;
    } t_bond_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [271:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;
    logic         i_cfg_wr_en;
    logic         i_cfg_wr_data;

    logic         grad_on;
    logic [63:0]  run_sum;
    logic         run_sat;
    t_bond_result expected_results [$];
    int           errors;
    int           bonds_sent;
    int           results_seen;
    int           grad_bonds;
    int           sat_results;
    int           burst_left;
    int           stall_kind;
    int           stall_left;

    bond_stretch_energy_gradient dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("bond_stretch_energy_gradient verification failed");
        $finish;
    end

    function automatic logic [63:0] mul_shr_sat(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + s)) != 0) begin
            return '1;
        end
        q = p >> s;
        return q[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] stretch_poly(logic [63:0] d2, logic [63:0] dmag,
                                                 logic dneg, logic [63:0] c, logic [63:0] m);
        logic [63:0] base;
        logic [63:0] lin;
        base = add_sat(64'd1 << 16, mul_shr_sat(d2, c, 32));
        lin  = dmag * m;
        if (dneg) begin
            return add_sat(base, lin);
        end
        return (base < lin) ? 64'd0 : base - lin;
    endfunction

    // advances the running sum; call once per accepted bond
    function automatic t_bond_result bond_term(t_bond b);
        t_bond_result res;
        logic [63:0]  mag [3];
        logic         neg [3];
        logic [127:0] dist2;
        logic [127:0] trial;
        logic [63:0]  r;
        logic [63:0]  dmag;
        logic         dneg;
        logic [63:0]  d2;
        logic [63:0]  e;
        logic [63:0]  q;
        logic [63:0]  gm;
        logic [63:0]  c;
        logic [63:0]  g [3];
        longint       d;
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
            d = longint'($signed(b.a_pos[i])) - longint'($signed(b.b_pos[i]));
            neg[i] = d < 0;
            mag[i] = neg[i] ? -d : d;
            dist2 += {64'd0, mag[i]} * {64'd0, mag[i]};
        end
        r = 0;
        for (int k = 33; k >= 0; k--) begin
            trial = {64'd0, r | (64'd1 << k)};
            if (trial * trial <= dist2) r = trial[63:0];
        end
        dneg = r < b.r0;
        dmag = dneg ? b.r0 - r : r - b.r0;
        d2 = (dmag * dmag) >> 16;
        e = mul_shr_sat(mul_shr_sat(mul_shr_sat(b.kb, d2, 16),
                        stretch_poly(d2, dmag, dneg, C_7_3, 2), 16), C_HALF_E, 32);
        if (e > MAX48) begin
            e = MAX48;
            run_sat = 1'b1;
        end
        run_sum += e;
        if (run_sum > MAX63) begin
            run_sum = MAX63;
            run_sat = 1'b1;
        end
        for (int i = 0; i < 3; i++) g[i] = 0;
        if (grad_on && r != 0) begin
            q  = stretch_poly(d2, dmag, dneg, C_14_3, 3);
            gm = mul_shr_sat(mul_shr_sat((b.kb * dmag) >> 16, q, 16), C_FULL_E, 32);
            for (int i = 0; i < 3; i++) begin
                c = mul_shr_sat(gm, (mag[i] << 31) / r, 31);
                if (c > MAX47) c = MAX47;
                g[i] = (neg[i] != dneg) ? -c : c;
            end
        end
        res.a_idx   = b.a_idx;
        res.b_idx   = b.b_idx;
        res.gx      = g[0][47:0];
        res.gy      = g[1][47:0];
        res.gz      = g[2][47:0];
        res.energy  = e[47:0];
        res.total   = run_sum[62:0];
        res.run_end = b.last;
        res.sat     = run_sat;
        if (b.last) begin
            run_sum = 0;
            run_sat = 1'b0;
        end
        return res;
    endfunction

    task automatic send_bond(t_bond b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, b.r0, b.kb, b.b_pos[2], b.b_pos[1], b.b_pos[0],
                          b.a_pos[2], b.a_pos[1], b.a_pos[0], b.b_idx, b.a_idx};
        s_axis_tlast  <= b.last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results = {expected_results, bond_term(b)};
        bonds_sent++;
        if (grad_on) grad_bonds++;
    endtask

    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        drain_words();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        grad_on = mode;
        @(posedge i_clk);
    endtask

    function automatic t_bond near_bond(logic last);
        t_bond b;
        b.a_idx = 16'($urandom);
        b.b_idx = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
            b.a_pos[i] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            b.b_pos[i] = b.a_pos[i] + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        end
        b.kb   = 24'($urandom_range(0, 24'h0F_FFFF));
        b.r0   = 20'($urandom_range(32'h0_8000, 32'h2_8000));
        b.last = last;
        return b;
    endfunction

    function automatic t_bond wild_bond();
        t_bond b;
        b.a_idx = 16'($urandom);
        b.b_idx = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
            b.a_pos[i] = $urandom;
            b.b_pos[i] = $urandom;
        end
        b.kb   = 24'($urandom);
        b.r0   = 20'($urandom);
        b.last = $urandom_range(0, 3) == 0;
        return b;
    endfunction

    task automatic test_directed(logic mode);
        t_bond b;
        write_mode(mode);
        b = near_bond(1'b0);
        b.b_pos = b.a_pos;
        send_bond(b);
        b.r0 = 0;
        send_bond(b);
        b = near_bond(1'b0);
        b.b_pos[0] = b.a_pos[0] + 32'h0001_8000;
        b.b_pos[1] = b.a_pos[1];
        b.b_pos[2] = b.a_pos[2];
        b.r0 = 20'h1_8000;
        send_bond(b);
        b.r0 = 20'hF_FFFF;
        b.kb = 24'hFF_FFFF;
        send_bond(b);
        b.r0 = 0;
        send_bond(b);
        b.a_idx = 16'hFFFF;
        b.b_idx = 16'h0000;
        for (int i = 0; i < 3; i++) begin
            b.a_pos[i] = 32'h7FFF_FFFF;
            b.b_pos[i] = 32'h8000_0000;
        end
        send_bond(b);
        b.a_idx = 16'h0000;
        b.b_idx = 16'hFFFF;
        for (int i = 0; i < 3; i++) begin
            b.a_pos[i] = 32'h8000_0000;
            b.b_pos[i] = 32'h7FFF_FFFF;
        end
        b.last = 1'b1;
        send_bond(b);
        b = near_bond(1'b1);
        b.kb = 0;
        send_bond(b);
        for (int i = 0; i < 3; i++) begin
            b.a_pos[i] = -32'sd65536 * (i + 1);
            b.b_pos[i] = 32'sd65536 * (i + 1);
        end
        b.kb = 24'hFF_FFFF;
        b.r0 = 0;
        b.last = 1'b0;
        send_bond(b);
        b.last = 1'b1;
        send_bond(b);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                send_bond(near_bond($urandom_range(0, 7) == 0));
            end else begin
                send_bond(wild_bond());
            end
        end
    endtask

    task automatic test_pause_idle();
        test_random(20);
        drain_words();
        test_random(20);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stall_kind    <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_kind <= $urandom_range(0, 2);
                stall_left <= $urandom_range(50, 600);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_kind)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready <= (stall_left % 16) < 5;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_bond_result want;
        t_bond_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[79:32],
                   m_axis_tdata[127:80], m_axis_tdata[175:128], m_axis_tdata[223:176],
                   m_axis_tdata[286:224], m_axis_tlast, m_axis_tuser};
            results_seen++;
            if (m_axis_tuser) sat_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
            end else begin
                want = expected_results.pop_front();
                if (got.a_idx != want.a_idx)
                    $display("%0t: a_idx exp %h got %h", $time, want.a_idx, got.a_idx);
                if (got.b_idx != want.b_idx)
                    $display("%0t: b_idx exp %h got %h", $time, want.b_idx, got.b_idx);
                if (got.gx != want.gx)
                    $display("%0t: grad_x exp %h got %h", $time, want.gx, got.gx);
                if (got.gy != want.gy)
                    $display("%0t: grad_y exp %h got %h", $time, want.gy, got.gy);
                if (got.gz != want.gz)
                    $display("%0t: grad_z exp %h got %h", $time, want.gz, got.gz);
                if (got.energy != want.energy)
                    $display("%0t: energy exp %h got %h", $time, want.energy, got.energy);
                if (got.total != want.total)
                    $display("%0t: total exp %h got %h", $time, want.total, got.total);
                if (got.run_end != want.run_end)
                    $display("%0t: run_end exp %b got %b", $time, want.run_end, got.run_end);
                if (got.sat != want.sat)
                    $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
                if (got != want) errors++;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        grad_on = 1'b0;
        run_sum = 0;
        run_sat = 1'b0;
        errors = 0;
        bonds_sent = 0;
        results_seen = 0;
        grad_bonds = 0;
        sat_results = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed(1'b0);
        test_directed(1'b1);
        test_random(500);
        test_pause_idle();
        write_mode(1'b0);
        test_random(500);
        write_mode(1'b1);
        test_random(500);
        drain_words();
        if (expected_results.size() != 0) errors++;
        $display("%0d bonds sent (%0d in gradient mode), %0d words checked",
                 bonds_sent, grad_bonds, results_seen);
        $display("%0d words flagged saturated, %0d mismatches", sat_results, errors);
        if (errors == 0) begin
            $display("bond_stretch_energy_gradient verification clean");
        end else begin
            $display("bond_stretch_energy_gradient verification failed");
        end
        $finish;
    end

endmodule
